// ----- rtl/scit_pkg.sv -----
// shared constants and types for the segment/circle hit test pipeline
// used by scit_umul and segment_circle_intersect_test_top, no dependencies
package scit_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 12;
  localparam int OUT_TDATA_W    = 8;

  // load enables for the two register stages of the split multiplier
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

endpackage

// ----- rtl/scit_umul.sv -----
// two-stage unsigned multiplier built from four half-width partial products
// depends on scit_pkg (mul_en_t)
module scit_umul #(
  parameter int W = 33
) (
  input  logic               clk,
  input  scit_pkg::mul_en_t  en,
  input  logic [W-1:0]       x,
  input  logic [W-1:0]       y,
  output logic [2*W-1:0]     p
);

  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] xe;
  logic [2*H-1:0] ye;
  logic [2*H-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [2*H:0]   mid;
  logic [4*H-1:0] full;
  logic [2*W-1:0] p_r;

  assign xe = (2*H)'(x);
  assign ye = (2*H)'(y);

  always_ff @(posedge clk) begin
    if (en.pp) begin
      ll_r <= xe[H-1:0] * ye[H-1:0];
      lh_r <= xe[H-1:0] * ye[2*H-1:H];
      hl_r <= xe[2*H-1:H] * ye[H-1:0];
      hh_r <= xe[2*H-1:H] * ye[2*H-1:H];
    end
  end

  // cross terms meet once, then one wide add against the outer terms
  assign mid  = {1'b0, lh_r} + {1'b0, hl_r};
  assign full = {hh_r, ll_r} + ((4*H)'(mid) << H);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p_r <= full[2*W-1:0];
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/segment_circle_intersect_test_top.sv -----
// segment versus circle hit test, seven register stages
// throughput one word per cycle while the output is not stalled
// each stage holds its own valid bit and advances when the stage after it has room,
// so a stall on the output only backs up as far as the first empty stage
// the two wide products are split into four partial products over two stages
// reset (rst_n low, synchronous) clears the valid bits only; depends on scit_pkg, scit_umul
module segment_circle_intersect_test_top #(
  parameter int COORD_BITS = scit_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // center_x, center_y, radius, start_x, start_y, end_x, end_y, zero fill
  input  logic [((6*COORD_BITS+scit_pkg::RADIUS_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // hit, zero fill
  output logic [scit_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);

  localparam int N      = COORD_BITS;
  localparam int RB     = scit_pkg::RADIUS_BITS;
  localparam int PW     = 2 * N + 2;
  localparam int WW     = (2 * N + 5 > 2 * RB + 4) ? 2 * N + 5 : 2 * RB + 4;
  localparam int MW     = 2 * N + 1;
  localparam int NSTG   = 7;
  localparam int OFF_CY = N;
  localparam int OFF_R  = 2 * N;
  localparam int OFF_SX = 2 * N + RB;
  localparam int OFF_SY = 3 * N + RB;
  localparam int OFF_EX = 4 * N + RB;
  localparam int OFF_EY = 5 * N + RB;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;
  logic            in_fire;

  // field slices
  logic signed [N-1:0] cx, cy, sx, sy, ex, ey;
  logic [RB-1:0]       rad;

  assign cx  = in_tdata[0 +: N];
  assign cy  = in_tdata[OFF_CY +: N];
  assign rad = in_tdata[OFF_R +: RB];
  assign sx  = in_tdata[OFF_SX +: N];
  assign sy  = in_tdata[OFF_SY +: N];
  assign ex  = in_tdata[OFF_EX +: N];
  assign ey  = in_tdata[OFF_EY +: N];

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: direction and offset vectors
  logic signed [N:0] dx_nxt, dy_nxt, fx_nxt, fy_nxt;
  logic signed [N:0] dx_r, dy_r, fx_r, fy_r;
  logic [RB-1:0]     r1_r;
  logic              zl1_r;

  assign dx_nxt = (N+1)'(ex) - (N+1)'(sx);
  assign dy_nxt = (N+1)'(ey) - (N+1)'(sy);
  assign fx_nxt = (N+1)'(sx) - (N+1)'(cx);
  assign fy_nxt = (N+1)'(sy) - (N+1)'(cy);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      r1_r  <= rad;
      zl1_r <= (dx_nxt == '0) && (dy_nxt == '0);
    end
  end

  // stage 2: the seven products
  logic signed [PW-1:0] dxx_r, dyy_r, fxdx_r, fydy_r, fxx_r, fyy_r;
  logic [2*RB-1:0]      rr_r;
  logic                 zl2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dxx_r  <= dx_r * dx_r;
      dyy_r  <= dy_r * dy_r;
      fxdx_r <= fx_r * dx_r;
      fydy_r <= fy_r * dy_r;
      fxx_r  <= fx_r * fx_r;
      fyy_r  <= fy_r * fy_r;
      rr_r   <= r1_r * r1_r;
      zl2_r  <= zl1_r;
    end
  end

  // stage 3: quadratic coefficients, b kept as half of b
  logic signed [WW-1:0] a_r, bh_r, c_r;
  logic                 zl3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      a_r   <= WW'(dxx_r) + WW'(dyy_r);
      bh_r  <= WW'(fxdx_r) + WW'(fydy_r);
      c_r   <= WW'(fxx_r) + WW'(fyy_r) - WW'(signed'({1'b0, rr_r}));
      zl3_r <= zl2_r;
    end
  end

  // stage 4: end values, vertex checks and the early decision
  logic signed [WW-1:0] g1, abh, bh_neg;
  logic                 c_neg, c_zero, g_neg, g_zero, bh_pos, abh_neg;
  logic                 dec4_nxt, early4_nxt;
  logic                 dec4_r, early4_r;
  logic [MW-1:0]        am_r, bm_r, cm_r;

  assign g1      = a_r + (bh_r <<< 1) + c_r;
  assign abh     = a_r + bh_r;
  assign bh_neg  = -bh_r;
  assign c_neg   = c_r[WW-1];
  assign c_zero  = (c_r == '0);
  assign g_neg   = g1[WW-1];
  assign g_zero  = (g1 == '0);
  assign bh_pos  = !bh_r[WW-1] && (bh_r != '0);
  assign abh_neg = abh[WW-1];

  always_comb begin
    dec4_nxt   = 1'b1;
    early4_nxt = 1'b0;
    if (zl3_r) begin
      early4_nxt = 1'b0;
    end else if (c_zero || g_zero) begin
      early4_nxt = 1'b1;
    end else if (c_neg != g_neg) begin
      early4_nxt = 1'b1;
    end else if (c_neg) begin
      early4_nxt = 1'b0;
    end else if (bh_pos || abh_neg) begin
      early4_nxt = 1'b0;
    end else begin
      // both ends outside, vertex on the segment: needs the discriminant
      dec4_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dec4_r   <= dec4_nxt;
      early4_r <= early4_nxt;
      am_r     <= a_r[MW-1:0];
      bm_r     <= bh_neg[MW-1:0];
      cm_r     <= c_r[MW-1:0];
    end
  end

  // stages 5 and 6: (b/2)^2 and a*c on magnitudes
  scit_pkg::mul_en_t mul_en;
  logic [2*MW-1:0]   sq, ac;
  logic              dec5_r, early5_r, dec6_r, early6_r;

  assign mul_en.pp  = adv[4];
  assign mul_en.sum = adv[5];

  scit_umul #(.W(MW)) u_mul_bb (
    .clk (clk),
    .en  (mul_en),
    .x   (bm_r),
    .y   (bm_r),
    .p   (sq)
  );

  scit_umul #(.W(MW)) u_mul_ac (
    .clk (clk),
    .en  (mul_en),
    .x   (am_r),
    .y   (cm_r),
    .p   (ac)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      dec5_r   <= dec4_r;
      early5_r <= early4_r;
    end
    if (adv[5]) begin
      dec6_r   <= dec5_r;
      early6_r <= early5_r;
    end
  end

  // stage 7: discriminant compare into the output register
  logic hit_nxt, hit_r;

  assign hit_nxt = dec6_r ? early6_r : (sq >= ac);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {{(scit_pkg::OUT_TDATA_W-1){1'b0}}, hit_r};

  // a stalled word in the vertex stage stays put
  a_hold_s4: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !adv[3] |=> v_r[3])
    else $error("stage 4 word lost under stall");

  // a zero-length segment always leaves stage 4 as a decided miss
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    adv[3] && v_r[2] && zl3_r |=> dec4_r && !early4_r)
    else $error("zero-length segment not forced to miss");

  // an empty first stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_tready)
    else $error("input blocked with empty first stage");

endmodule

// ----- tb/testbench.sv -----
// self-checking bench for the segment versus circle hit test pipeline
// drives query words on the input stream, predicts the hit bit and checks the output stream
// depends on scit_pkg and segment_circle_intersect_test_top
module testbench;

  localparam int COORD_W = 16;
  localparam int IN_W    = ((6*COORD_W + scit_pkg::RADIUS_BITS + 7) / 8) * 8;
  localparam int N_RANDOM  = 800;
  localparam int CYCLE_CAP = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NO_EXPECT = -1;

  typedef struct {
    int cx, cy, r, sx, sy, ex, ey;
    int hit;
  } query_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [IN_W-1:0]                 in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [scit_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;

  bit         hit_expect_q[$];
  query_row_t query_rows[$];
  int         err_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  segment_circle_intersect_test_top #(.COORD_BITS(COORD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // fields from the lowest bit up: center_x, center_y, radius, start_x, start_y, end_x, end_y
  function automatic logic [IN_W-1:0] encode_query(input int cx, cy, r, sx, sy, ex, ey);
    logic [IN_W-1:0] w;
    w = '0;
    w[15:0]    = cx[15:0];
    w[31:16]   = cy[15:0];
    w[43:32]   = r[11:0];
    w[59:44]   = sx[15:0];
    w[75:60]   = sy[15:0];
    w[91:76]   = ex[15:0];
    w[107:92]  = ey[15:0];
    return w;
  endfunction

  function automatic bit predict_hit(input logic [IN_W-1:0] w);
    logic signed [15:0]  cx, cy, sx, sy, ex, ey;
    longint              rad, dx, dy, fx, fy, a, bh, c, g1;
    logic signed [159:0] wa, wbh, wc, disc;
    cx = w[15:0];   cy = w[31:16];
    sx = w[59:44];  sy = w[75:60];
    ex = w[91:76];  ey = w[107:92];
    rad = longint'(w[43:32]);
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    fx = longint'(sx) - longint'(cx);
    fy = longint'(sy) - longint'(cy);
    if (dx == 0 && dy == 0) return 1'b0;
    a  = dx*dx + dy*dy;
    bh = fx*dx + fy*dy;
    c  = fx*fx + fy*fy - rad*rad;
    // quadratic evaluated at t = 1
    g1 = a + 2*bh + c;
    if (c == 0 || g1 == 0) return 1'b1;
    if ((c < 0) != (g1 < 0)) return 1'b1;
    if (c < 0) return 1'b0;
    // both ends outside: vertex must fall on the segment and the discriminant be >= 0
    if (bh > 0) return 1'b0;
    if (a + bh < 0) return 1'b0;
    wa = a; wbh = bh; wc = c;
    disc = wbh*wbh - wa*wc;
    if (disc < 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int n;
    if (calm) return 0;
    n = $urandom_range(0, 99);
    if (n < 55) return 0;
    if (n < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int jitter(input int span);
    int v;
    v = $urandom_range(0, 2*span);
    return v - span;
  endfunction

  task automatic table_row(input int cx, cy, r, sx, sy, ex, ey, input int hit);
    query_row_t row;
    row.cx = cx; row.cy = cy; row.r = r;
    row.sx = sx; row.sy = sy; row.ex = ex; row.ey = ey;
    row.hit = hit;
    query_rows.insert(query_rows.size(), row);
  endtask

  // hit < 0 means the expectation comes from the predictor
  task automatic send_query(input logic [IN_W-1:0] w, input int hit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    if (hit < 0) hit_expect_q.insert(hit_expect_q.size(), predict_hit(w));
    else hit_expect_q.insert(hit_expect_q.size(), hit[0]);
  endtask

  // output side stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tready) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_expect_q.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got hit %0b", $time, out_tdata[0]);
        err_count++;
      end else begin
        bit want;
        want = hit_expect_q.pop_front();
        if (out_tdata[0] !== want) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want, out_tdata[0]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int kind, cx, cy, r, sx, sy, ex, ey, span, k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length segments
    table_row(-32768, -32768, 0, -32768, -32768, -32768, -32768, 0);
    table_row(32767, 32767, 4095, 32767, 32767, 32767, 32767, 0);
    table_row(0, 0, 16, 100, -50, 100, -50, NO_EXPECT);
    // wholly inside
    table_row(0, 0, 4095, 10, 10, 20, 20, 0);
    // tangent touch at (0,16)
    table_row(0, 0, 16, -32, 16, 32, 16, 1);
    // end point on the circle
    table_row(0, 0, 16, 16, 0, 100, 0, 1);
    table_row(0, 0, 4095, -4095, 0, 4095, 0, 1);
    // point circle on the segment and just off it
    table_row(5, 5, 0, 0, 0, 10, 10, 1);
    table_row(5, 6, 0, 0, 0, 10, 10, NO_EXPECT);
    // full-range diagonal through the center, then full-range edge segments with corner circles
    table_row(0, 0, 4095, -32768, -32768, 32767, 32767, 1);
    table_row(32767, -32768, 4095, -32768, 32767, 32767, 32767, NO_EXPECT);
    table_row(-32768, 32767, 4095, 32767, -32768, -32768, -32768, NO_EXPECT);
    table_row(32767, 32767, 0, -32768, -32768, -32768, 32767, NO_EXPECT);
    // one end in, one end out
    table_row(0, 0, 16, 0, 0, 100, 0, 1);
    // passing through, both ends outside
    table_row(0, 0, 16, -100, 0, 100, 0, 1);
    // pointing away, vertex before the start
    table_row(0, 0, 16, 100, 0, 200, 0, 0);
    // vertex past the end
    table_row(0, 0, 16, -200, 0, -100, 0, 0);
    // line misses the circle
    table_row(0, 0, 16, -100, 50, 100, 50, 0);
    table_row(0, 0, 16, 100, 100, 200, 100, 0);
    table_row(-1000, 2000, 300, -1500, 1500, -500, 2600, NO_EXPECT);

    foreach (query_rows[i])
      send_query(encode_query(query_rows[i].cx, query_rows[i].cy, query_rows[i].r,
                              query_rows[i].sx, query_rows[i].sy,
                              query_rows[i].ex, query_rows[i].ey), query_rows[i].hit);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      r  = $urandom_range(0, 4095);
      span = 2*r + 64;
      sx = cx + jitter(span); sy = cy + jitter(span);
      ex = cx + jitter(span); ey = cy + jitter(span);
      if (kind >= 50 && kind < 60) begin
        // start exactly on the circle
        case ($urandom_range(0, 3))
          0: begin sx = cx + r; sy = cy; end
          1: begin sx = cx - r; sy = cy; end
          2: begin sx = cx; sy = cy + r; end
          default: begin sx = cx; sy = cy - r; end
        endcase
      end else if (kind >= 60 && kind < 68) begin
        // horizontal line tangent at the top or the bottom, touch point on or off the segment
        k = $urandom_range(0, 1) ? r + 1 : -r - 1;
        sy = cy + k - ((k > 0) ? 1 : -1);
        ey = sy;
        sx = cx + jitter(span);
        ex = cx + jitter(span);
      end else if (kind >= 68 && kind < 73) begin
        ex = sx; ey = sy;
      end else if (kind >= 73 && kind < 80) begin
        sx = cx + jitter(r/2); sy = cy + jitter(r/2);
        ex = cx + jitter(r/2); ey = cy + jitter(r/2);
      end else if (kind >= 80) begin
        sx = $urandom_range(0, 65535); sy = $urandom_range(0, 65535);
        ex = $urandom_range(0, 65535); ey = $urandom_range(0, 65535);
      end
      send_query(encode_query(cx, cy, r, sx, sy, ex, ey), NO_EXPECT);
    end
    in_tvalid <= 1'b0;

    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
